/* design/pnpf_pkg.sv */
// Shared types, codes and helper functions of the per-node page free-list allocator.
// No dependencies; the top level and pnpf_lists refer to this package by scoped names.

package pnpf_pkg;

   // Default configuration of the allocator
   localparam int PAGE_COUNT_DEF = 65536;
   localparam int NODE_COUNT_DEF = 4;
   localparam int PAGE_BYTES_DEF = 4096;

   // Widest page number and node number that any legal configuration needs
   localparam int PAGE_W_MAX = 20;
   localparam int NODE_W_MAX = 4;
   // Wide enough for PAGE_COUNT * PAGE_BYTES at the largest configuration
   localparam int TOP_W      = 37;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [1:0] STAT_FREED     = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_BAD_ADDR  = 2'd3;

   typedef enum logic {
      FSM_IDLE,
      FSM_POP
   } state_type;

   // Write to one list head (push or completion of a pop)
   typedef struct packed {
      logic                  en;
      logic [NODE_W_MAX-1:0] node;
      logic [PAGE_W_MAX-1:0] head;
      logic                  nonempty;
   } list_upd_type;

   // Selected list as seen by the control logic
   typedef struct packed {
      logic                  any;
      logic [NODE_W_MAX-1:0] node;
      logic [PAGE_W_MAX-1:0] head;
      logic                  nonempty;
   } list_view_type;

   // value mod node_count without a divider: sum the residues of the powers of two
   // that are set, then reduce the small sum by a short restoring compare-subtract.
   function automatic logic [NODE_W_MAX-1:0] node_of(input logic [PAGE_W_MAX-1:0] value,
                                                     input int node_count);
      int          w;
      logic [13:0] acc;
      logic [13:0] lim;
      w   = (node_count > 1) ? 1 : 0;
      acc = '0;
      for (int i = 0; i < PAGE_W_MAX; i++) begin
         if (value[i]) begin
            acc = acc + 14'(w);
         end
         w = w * 2;
         if (w >= node_count) begin
            w = w - node_count;
         end
      end
      for (int k = 8; k >= 0; k--) begin
         lim = 14'(node_count) << k;
         if (acc >= lim) begin
            acc = acc - lim;
         end
      end
      return acc[NODE_W_MAX-1:0];
   endfunction

endpackage

/* design/per_node_page_free_list_allocator.sv */
// Top level of the per-node page free-list allocator: request decode, control FSM, responses.
// Depends on pnpf_pkg, pnpf_lists and pnpf_link_ram.

// Physical page allocator keeping one last-in-first-out free list per memory node.
// A request word is taken at a rising edge with start high and busy low. A free
// (opcode 1) checks the byte address: it must be page aligned, at or above the kernel
// end register and below PAGE_COUNT * PAGE_BYTES, else status 3 comes back and nothing
// changes. A good page is pushed on the list of node (page number mod NODE_COUNT). An
// allocate (opcode 0) searches the nodes round-robin from req_search_node mod NODE_COUNT
// and pops the first non-empty list; status 2 means every list is empty. Exactly one
// response word follows each request, on the cycle after acceptance, flagged by
// rsp_strobe for that single cycle; the receiver cannot stall it, so it must sample it
// then. A free, an empty allocate and a rejected free leave busy low; a successful
// allocate reads the popped page's successor from the link memory (a registered read)
// before the list head is rewritten, and busy is high while that rewrite takes place.
// Double frees are not detected. PAGE_BYTES must be a power of two. The kernel end
// register may be written at any time; csr_ready is always high.

module per_node_page_free_list_allocator #(
   parameter int PAGE_COUNT = pnpf_pkg::PAGE_COUNT_DEF,
   parameter int NODE_COUNT = pnpf_pkg::NODE_COUNT_DEF,
   parameter int PAGE_BYTES = pnpf_pkg::PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_phys_addr,
   input  logic [7:0]  req_search_node,
   // response channel
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_page_addr,
   output logic [3:0]  rsp_node,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [28:0] csr_kernel_end_addr
);

   localparam int PageW      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int NodeW      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int PageShift  = $clog2(PAGE_BYTES);
   localparam int TopW       = pnpf_pkg::TOP_W;
   localparam int PageWMax   = pnpf_pkg::PAGE_W_MAX;
   localparam int NodeWMax   = pnpf_pkg::NODE_W_MAX;
   localparam int LinkW      = PageW + 1;
   localparam logic [TopW-1:0] MemTop = TopW'(PAGE_COUNT) * TopW'(PAGE_BYTES);

   // ---------------------------------------------------------------- registers
   pnpf_pkg::state_type state_ff, state_in;
   logic [28:0]       kend_ff;
   logic [NodeW-1:0]  pop_node_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_page_addr_ff, rsp_page_addr_in;
   logic [3:0]        rsp_node_ff, rsp_node_in;

   // ---------------------------------------------------------------- decode
   logic              accept;
   logic              is_free;
   logic              bad_addr;
   logic [TopW-1:0]   addr_ext;
   logic [PageW-1:0]  page_num;
   logic [NodeW-1:0]  free_node;
   logic [NodeW-1:0]  start_node;
   logic [TopW-1:0]   alloc_addr_ext;

   pnpf_pkg::list_upd_type  upd;
   pnpf_pkg::list_view_type view;

   logic              mem_we;
   logic              mem_re;
   logic [PageW-1:0]  mem_waddr;
   logic [LinkW-1:0]  mem_wdata;
   logic [PageW-1:0]  mem_raddr;
   logic [LinkW-1:0]  mem_rdata;

   assign accept  = start && !busy;
   assign is_free = (req_opcode == pnpf_pkg::OP_FREE);

   // Reject misaligned, kernel-owned and beyond-top addresses
   assign addr_ext = TopW'(req_phys_addr);
   assign bad_addr = (req_phys_addr[PageShift-1:0] != '0)
                  || (req_phys_addr < {3'b000, kend_ff})
                  || (addr_ext >= MemTop);

   // In range, so the page number fits the index width
   assign page_num   = PageW'(req_phys_addr >> PageShift);
   assign free_node  = NodeW'(pnpf_pkg::node_of(PageWMax'(page_num), NODE_COUNT));
   assign start_node = NodeW'(pnpf_pkg::node_of(PageWMax'(req_search_node), NODE_COUNT));

   pnpf_lists #(
      .NODE_COUNT (NODE_COUNT),
      .PAGE_W     (PageW),
      .NODE_W     (NodeW)
   ) u_lists (
      .clock      (clock),
      .reset      (reset),
      .use_free   (is_free),
      .free_node  (free_node),
      .start_node (start_node),
      .upd        (upd),
      .view       (view)
   );

   // Push: link the new page to the current head of its list.
   // Pop: fetch the successor of the head being handed out.
   assign mem_we    = accept && is_free && !bad_addr;
   assign mem_waddr = page_num;
   assign mem_wdata = {view.nonempty, view.head[PageW-1:0]};
   assign mem_re    = accept && !is_free && view.any;
   assign mem_raddr = view.head[PageW-1:0];

   pnpf_link_ram #(
      .DEPTH  (PAGE_COUNT),
      .ADDR_W (PageW),
      .DATA_W (LinkW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // One head write a cycle: the pop completion owns the busy cycle, so it never
   // meets a push and the head it rewrites cannot be touched in between.
   always_comb begin
      upd = '0;
      if (state_ff == pnpf_pkg::FSM_POP) begin
         upd.en       = 1'b1;
         upd.node     = NodeWMax'(pop_node_ff);
         upd.head     = PageWMax'(mem_rdata[PageW-1:0]);
         upd.nonempty = mem_rdata[PageW];
      end else if (mem_we) begin
         upd.en       = 1'b1;
         upd.node     = NodeWMax'(free_node);
         upd.head     = PageWMax'(page_num);
         upd.nonempty = 1'b1;
      end
   end

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pnpf_pkg::FSM_IDLE: begin
            if (mem_re) begin
               state_in = pnpf_pkg::FSM_POP;
            end
         end
         pnpf_pkg::FSM_POP: begin
            state_in = pnpf_pkg::FSM_IDLE;
         end
         default: begin
            state_in = pnpf_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         pnpf_pkg::FSM_IDLE: busy = 1'b0;
         pnpf_pkg::FSM_POP:  busy = 1'b1;
         default:            busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnpf_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- response
   // Address of the page handed out, truncated to 32 bits
   assign alloc_addr_ext = TopW'(view.head[PageW-1:0]) << PageShift;

   always_comb begin
      rsp_status_in    = pnpf_pkg::STAT_EMPTY;
      rsp_page_addr_in = '0;
      rsp_node_in      = '0;
      if (is_free) begin
         if (bad_addr) begin
            rsp_status_in = pnpf_pkg::STAT_BAD_ADDR;
         end else begin
            rsp_status_in = pnpf_pkg::STAT_FREED;
            rsp_node_in   = 4'(free_node);
         end
      end else if (view.any) begin
         rsp_status_in    = pnpf_pkg::STAT_ALLOCATED;
         rsp_page_addr_in = alloc_addr_ext[31:0];
         rsp_node_in      = 4'(view.node[NodeW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // Hold the response word and the node being popped
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_page_addr_ff <= rsp_page_addr_in;
         rsp_node_ff      <= rsp_node_in;
         pop_node_ff      <= view.node[NodeW-1:0];
      end
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_page_addr = rsp_page_addr_ff;
   assign rsp_node      = rsp_node_ff;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kend_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         kend_ff <= csr_kernel_end_addr;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_rsp_follows_accept : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("response word without an accepted request");

   a_pop_after_alloc : assert property (@(posedge clock) disable iff (reset)
      (state_ff == pnpf_pkg::FSM_POP) |-> $past(accept && !is_free && view.any))
      else $error("pop cycle without a successful allocate");

   a_alloc_rsp_in_pop : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == pnpf_pkg::STAT_ALLOCATED) |-> busy)
      else $error("allocated response without the head update cycle");

   a_bad_rsp_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == pnpf_pkg::STAT_BAD_ADDR
                      || rsp_status == pnpf_pkg::STAT_EMPTY))
      |-> (rsp_page_addr == '0 && rsp_node == '0))
      else $error("failed request carries a page or node");

endmodule

/* design/pnpf_link_ram.sv */
// Link memory of the page free lists: one successor word per physical page.
// Synchronous single-write, single-read RAM with a registered read; uses no package items.

module pnpf_link_ram #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16,
   parameter int DATA_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pnpf_lists.sv */
// List heads and non-empty flags of every node, with the round-robin node search.
// Depends on pnpf_pkg for the list update and list view structs.

module pnpf_lists #(
   parameter int NODE_COUNT = 4,
   parameter int PAGE_W     = 16,
   parameter int NODE_W     = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   use_free,
   input  logic [NODE_W-1:0]      free_node,
   input  logic [NODE_W-1:0]      start_node,
   input  pnpf_pkg::list_upd_type upd,
   output pnpf_pkg::list_view_type view
);

   localparam int NodeWMax = pnpf_pkg::NODE_W_MAX;
   localparam int PageWMax = pnpf_pkg::PAGE_W_MAX;

   logic [PAGE_W-1:0] head_ff     [NODE_COUNT];
   logic              nonempty_ff [NODE_COUNT];

   logic              pick_found;
   logic [NODE_W-1:0] pick_node;
   logic [NODE_W-1:0] sel_node;
   logic [NODE_W:0]   idx;

   // Walk the nodes from the start node, wrapping once; take the first non-empty list
   always_comb begin
      pick_found = 1'b0;
      pick_node  = '0;
      idx        = '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         idx = {1'b0, start_node} + (NODE_W + 1)'(i);
         if (idx >= (NODE_W + 1)'(NODE_COUNT)) begin
            idx = idx - (NODE_W + 1)'(NODE_COUNT);
         end
         if (!pick_found && nonempty_ff[idx[NODE_W-1:0]]) begin
            pick_found = 1'b1;
            pick_node  = idx[NODE_W-1:0];
         end
      end
   end

   assign sel_node = use_free ? free_node : pick_node;

   always_comb begin
      view.any      = pick_found;
      view.node     = NodeWMax'(sel_node);
      view.head     = PageWMax'(head_ff[sel_node]);
      view.nonempty = nonempty_ff[sel_node];
   end

   always_ff @(posedge clock) begin
      if (upd.en) begin
         head_ff[upd.node[NODE_W-1:0]] <= upd.head[PAGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NODE_COUNT; n++) begin
            nonempty_ff[n] <= 1'b0;
         end
      end else if (upd.en) begin
         nonempty_ff[upd.node[NODE_W-1:0]] <= upd.nonempty;
      end
   end

endmodule
